@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the neighbor exchange block.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define NES_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define NES_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/nes_pkg.sv @@
// Types, constants and helper functions of the neighbor exchange schedule block.
// No dependencies; used by every module of the block.
package nes_pkg;

  // Fixed limits.
  localparam int MAX_NODES   = 32;
  localparam int REACH_LIMIT = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Field and register widths.
  localparam int RANK_W     = 5;
  localparam int CNT_W      = 6;
  localparam int MODE_W     = 3;
  localparam int REACH_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  // Operation kinds on the result channel.
  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  // Topology modes; codes 6 and 7 are unused and give no results.
  typedef enum logic [MODE_W-1:0] {
    MODE_EMPTY    = 3'd0,
    MODE_STAR     = 3'd1,
    MODE_RING     = 3'd2,
    MODE_COMPLETE = 3'd3,
    MODE_KRING    = 3'd4,
    MODE_TORUS    = 3'd5
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 3'd0,
    CFG_NODES   = 3'd1,
    CFG_REACH   = 3'd2,
    CFG_HEIGHT  = 3'd3,
    CFG_WIDTH   = 3'd4
  } cfg_reg_t;

  // Kind of schedule handed from the front end to the sequencer.
  typedef enum logic [2:0] {
    JOB_STAR_ROOT,
    JOB_STAR_LEAF,
    JOB_RING,
    JOB_COMPLETE,
    JOB_KRING,
    JOB_TORUS
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_EVAL,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  // Phases of the complete-graph schedule: sends below the rank, receives, sends above.
  typedef enum logic [1:0] {
    PH_LOW,
    PH_SELF,
    PH_HIGH
  } cplx_phase_t;

  // Current configuration as seen by the front end.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CNT_W-1:0]   node_count;
    logic [REACH_W-1:0] ring_reach;
    logic [CNT_W-1:0]   torus_h;
    logic [CNT_W-1:0]   torus_w;
  } cfg_t;

  // Classified request waiting in the queue.
  typedef struct packed {
    job_t              job;
    logic [RANK_W-1:0] rank;
    logic [CNT_W-1:0]  size;
    logic [3:0]        reach_m1;
    logic [RANK_W-1:0] pa;
    logic [RANK_W-1:0] pb;
    logic              even;
    logic [RANK_W-1:0] pc;
    logic [RANK_W-1:0] pd;
    logic              even2;
  } desc_t;

  typedef struct packed {
    logic              kind;
    logic [RANK_W-1:0] peer;
  } op_t;

  // Bit r of entry i-1 is the parity of r / i, for i from 1 to 16.
  localparam logic [31:0] PAR_TBL [REACH_LIMIT] = '{
    32'hAAAAAAAA, 32'hCCCCCCCC, 32'h38E38E38, 32'hF0F0F0F0,
    32'h3E0F83E0, 32'hC0FC0FC0, 32'h0FE03F80, 32'hFF00FF00,
    32'hF803FE00, 32'hC00FFC00, 32'h003FF800, 32'h00FFF000,
    32'h03FFE000, 32'h0FFFC000, 32'h3FFF8000, 32'hFFFF0000
  };

  // One step of a four-operation exchange with forward neighbor a and backward neighbor b.
  function automatic op_t xchg_op(input logic [1:0] sub, input logic even,
                                  input logic [RANK_W-1:0] a, input logic [RANK_W-1:0] b);
    op_t op;
    unique case (sub)
      2'd0: begin
        op.kind = even ? OP_SEND : OP_RECV;
        op.peer = even ? a : b;
      end
      2'd1: begin
        op.kind = even ? OP_RECV : OP_SEND;
        op.peer = even ? b : a;
      end
      2'd2: begin
        op.kind = even ? OP_SEND : OP_RECV;
        op.peer = even ? b : a;
      end
      default: begin
        op.kind = even ? OP_RECV : OP_SEND;
        op.peer = even ? a : b;
      end
    endcase
    return op;
  endfunction

endpackage

@@ src/nes_front.sv @@
// Front end of the neighbor exchange block: accepts a rank, checks it against the
// topology and builds a schedule descriptor for the queue. Depends on nes_pkg.
module nes_front
  import nes_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RANK_W-1:0] in_node_rank,
  input  cfg_t              cfg,
  output logic              push,
  output desc_t             push_desc,
  input  logic              full
);

  front_state_t      state_r, state_nxt;
  logic [RANK_W-1:0] rank_r;
  logic [RANK_W-1:0] rem_r;
  logic [RANK_W-1:0] row_r;
  logic [CNT_W-1:0]  hw_r;
  desc_t             desc_r;

  logic [CNT_W-1:0]   size;
  logic [CNT_W-1:0]   size_m1;
  logic [REACH_W-1:0] reach;
  logic [REACH_W-1:0] reach_m1;
  logic [11:0]        hw_full;
  logic               in_range;
  logic [RANK_W-1:0]  ring_fwd;
  logic [RANK_W-1:0]  ring_bwd;
  logic               eval_drop;
  logic               eval_div;
  desc_t              eval_desc;
  logic               accept;

  // Torus coordinates and neighbors, valid once the division has finished.
  logic               rem_ge;
  logic [RANK_W-1:0]  base;
  logic [CNT_W-1:0]   col_p1;
  logic [CNT_W-1:0]   w_m1;
  logic [6:0]         up_sum;
  logic [6:0]         dn_sum;
  desc_t              torus_desc;

  assign accept = in_valid && !in_stall;

  // Saturated node count and reach.
  always_comb begin
    size     = (cfg.node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : cfg.node_count;
    size_m1  = size - CNT_W'(1);
    reach    = (cfg.ring_reach > REACH_W'(REACH_LIMIT)) ? REACH_W'(REACH_LIMIT)
                                                        : cfg.ring_reach;
    reach_m1 = reach - REACH_W'(1);
    hw_full  = {6'd0, cfg.torus_h} * {6'd0, cfg.torus_w};
    in_range = {1'b0, rank_r} < size;
    ring_fwd = ({1'b0, rank_r} + CNT_W'(1) == size) ? '0 : rank_r + RANK_W'(1);
    ring_bwd = (rank_r == '0) ? size_m1[RANK_W-1:0] : rank_r - RANK_W'(1);
  end

  // Classify the accepted rank.
  always_comb begin
    eval_desc          = '0;
    eval_desc.rank     = rank_r;
    eval_desc.size     = size;
    eval_desc.reach_m1 = reach_m1[3:0];
    eval_desc.pa       = ring_fwd;
    eval_desc.pb       = ring_bwd;
    eval_desc.even     = ~rank_r[0];
    eval_desc.job      = JOB_RING;
    eval_drop          = 1'b1;
    eval_div           = 1'b0;
    unique case (cfg.mode)
      MODE_STAR: begin
        eval_drop     = !in_range || (rank_r == '0 && size == CNT_W'(1));
        eval_desc.job = (rank_r == '0) ? JOB_STAR_ROOT : JOB_STAR_LEAF;
      end
      MODE_RING: begin
        eval_drop     = !in_range;
        eval_desc.job = JOB_RING;
      end
      MODE_COMPLETE: begin
        eval_drop     = !in_range || size == CNT_W'(1);
        eval_desc.job = JOB_COMPLETE;
      end
      MODE_KRING: begin
        eval_drop     = !in_range || cfg.ring_reach == '0;
        eval_desc.job = JOB_KRING;
      end
      MODE_TORUS: begin
        eval_drop = hw_full == '0 || hw_full > 12'(MAX_NODES) || {7'd0, rank_r} >= hw_full;
        eval_div  = !eval_drop;
      end
      default: begin
        eval_drop = 1'b1;
      end
    endcase
  end

  // Torus neighbors from row = quotient and col = remainder.
  always_comb begin
    rem_ge   = {1'b0, rem_r} >= cfg.torus_w;
    base     = rank_r - rem_r;
    col_p1   = {1'b0, rem_r} + CNT_W'(1);
    w_m1     = cfg.torus_w - CNT_W'(1);
    up_sum   = {2'b0, rank_r} + {1'b0, cfg.torus_w};
    dn_sum   = {2'b0, rank_r} + {1'b0, hw_r} - {1'b0, cfg.torus_w};

    torus_desc       = '0;
    torus_desc.job   = JOB_TORUS;
    torus_desc.rank  = rank_r;
    torus_desc.size  = hw_r;
    torus_desc.pa    = (col_p1 == cfg.torus_w) ? base : rank_r + RANK_W'(1);
    torus_desc.pb    = (rem_r == '0) ? base + w_m1[RANK_W-1:0] : rank_r - RANK_W'(1);
    torus_desc.even  = ~rem_r[0];
    torus_desc.pc    = (up_sum >= {1'b0, hw_r}) ? 5'(up_sum - {1'b0, hw_r}) : up_sum[4:0];
    torus_desc.pd    = ({1'b0, rank_r} >= cfg.torus_w) ? rank_r - cfg.torus_w[RANK_W-1:0]
                                                       : dn_sum[4:0];
    torus_desc.even2 = ~row_r[0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) state_nxt = F_EVAL;
      end
      F_EVAL: begin
        if (eval_drop)     state_nxt = F_IDLE;
        else if (eval_div) state_nxt = F_DIV;
        else               state_nxt = F_PUSH;
      end
      F_DIV: begin
        if (!rem_ge) state_nxt = F_PUSH;
      end
      default: begin
        if (!full) state_nxt = F_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall  = state_r != F_IDLE;
    push      = state_r == F_PUSH && !full;
    push_desc = desc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers: rank, division by repeated subtraction, descriptor.
  always_ff @(posedge clk) begin
    if (accept) rank_r <= in_node_rank;
    if (state_r == F_EVAL) begin
      rem_r <= rank_r;
      row_r <= '0;
      hw_r  <= hw_full[CNT_W-1:0];
      if (!eval_div) desc_r <= eval_desc;
    end
    if (state_r == F_DIV) begin
      if (rem_ge) begin
        rem_r <= rem_r - cfg.torus_w[RANK_W-1:0];
        row_r <= row_r + RANK_W'(1);
      end else begin
        desc_r <= torus_desc;
      end
    end
  end

endmodule

@@ src/nes_queue.sv @@
// Short descriptor queue between the front end and the sequencer.
// Depends on nes_pkg for the descriptor type and depth.
module nes_queue
  import nes_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output desc_t head,
  output logic  empty
);

  desc_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = slot_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_desc;
  end

endmodule

@@ src/nes_back.sv @@
// Sequencer of the neighbor exchange block (depends on nes_pkg): walks one descriptor
// and emits one operation per cycle into the output register while it is not stalled.
module nes_back
  import nes_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  desc_t             head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_op_kind,
  output logic [RANK_W-1:0] out_peer_node,
  output logic              out_last_op
);

  back_state_t       state_r, state_nxt;
  job_t              job_r;
  logic [RANK_W-1:0] rank_r;
  logic [CNT_W-1:0]  size_r;
  logic [3:0]        km_r;
  logic [3:0]        xm_r;
  logic [RANK_W-1:0] pa_r, pb_r, pc_r, pd_r;
  logic              even_r, even2_r, second_r;
  logic [1:0]        sub_r;
  logic [CNT_W-1:0]  c_r;
  cplx_phase_t       phase_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [RANK_W-1:0] out_peer_r;
  logic              out_last_r;

  logic              can_emit;
  logic              emit;
  op_t               xop;
  logic              cur_kind;
  logic [RANK_W-1:0] cur_peer;
  logic              cur_last;

  // Next sequencer values after the current operation.
  logic [1:0]        sub_nxt;
  logic [3:0]        xm_nxt;
  logic [RANK_W-1:0] pa_nxt, pb_nxt;
  logic              even_nxt, second_nxt;
  logic [CNT_W-1:0]  c_nxt;
  cplx_phase_t       phase_nxt;

  logic [6:0]        c_p1, c_p2, self_nxt, size_ext, rank_ext;
  logic [3:0]        xm_p1;

  assign can_emit = !out_valid_r || !out_stall;

  // Current operation and the step after it.
  always_comb begin
    xop      = xchg_op(sub_r, even_r, pa_r, pb_r);
    c_p1     = {1'b0, c_r} + 7'd1;
    c_p2     = {1'b0, c_r} + 7'd2;
    size_ext = {1'b0, size_r};
    rank_ext = {2'b0, rank_r};
    self_nxt = (c_p1 == rank_ext) ? c_p2 : c_p1;
    xm_p1    = xm_r + 4'd1;

    cur_kind   = xop.kind;
    cur_peer   = xop.peer;
    cur_last   = 1'b0;
    sub_nxt    = sub_r + 2'd1;
    xm_nxt     = xm_r;
    pa_nxt     = pa_r;
    pb_nxt     = pb_r;
    even_nxt   = even_r;
    second_nxt = second_r;
    c_nxt      = c_p1[CNT_W-1:0];
    phase_nxt  = phase_r;

    unique case (job_r)
      JOB_STAR_ROOT: begin
        cur_kind = OP_RECV;
        cur_peer = c_r[RANK_W-1:0];
        cur_last = c_p1 == size_ext;
      end
      JOB_STAR_LEAF: begin
        cur_kind = OP_SEND;
        cur_peer = '0;
        cur_last = 1'b1;
      end
      JOB_RING: begin
        cur_last = sub_r == 2'd1;
      end
      JOB_COMPLETE: begin
        cur_peer = c_r[RANK_W-1:0];
        unique case (phase_r)
          PH_LOW: begin
            cur_kind = OP_SEND;
            if (c_p1 == rank_ext) begin
              phase_nxt = PH_SELF;
              c_nxt     = '0;
            end
          end
          PH_SELF: begin
            cur_kind = OP_RECV;
            cur_last = self_nxt >= size_ext && rank_ext + 7'd1 >= size_ext;
            if (self_nxt >= size_ext) begin
              phase_nxt = PH_HIGH;
              c_nxt     = {1'b0, rank_r} + CNT_W'(1);
            end else begin
              c_nxt = self_nxt[CNT_W-1:0];
            end
          end
          default: begin
            cur_kind = OP_SEND;
            cur_last = c_p1 == size_ext;
          end
        endcase
      end
      JOB_KRING: begin
        cur_last = sub_r == 2'd3 && xm_r == km_r;
        if (sub_r == 2'd3) begin
          xm_nxt   = xm_p1;
          pa_nxt   = ({1'b0, pa_r} + CNT_W'(1) == size_r) ? '0 : pa_r + RANK_W'(1);
          pb_nxt   = (pb_r == '0) ? 5'(size_r - CNT_W'(1)) : pb_r - RANK_W'(1);
          even_nxt = ~PAR_TBL[xm_p1][rank_r];
        end
      end
      default: begin
        cur_last = sub_r == 2'd3 && second_r;
        if (sub_r == 2'd3) begin
          pa_nxt     = pc_r;
          pb_nxt     = pd_r;
          even_nxt   = even2_r;
          second_nxt = 1'b1;
        end
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!empty) state_nxt = B_RUN;
      end
      default: begin
        if (can_emit && cur_last) state_nxt = B_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    pop           = state_r == B_IDLE && !empty;
    emit          = state_r == B_RUN && can_emit;
    out_valid     = out_valid_r;
    out_op_kind   = out_kind_r;
    out_peer_node = out_peer_r;
    out_last_op   = out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Sequencer registers: loaded from the queue head, stepped on each emitted item.
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r    <= head.job;
      rank_r   <= head.rank;
      size_r   <= head.size;
      km_r     <= head.reach_m1;
      xm_r     <= '0;
      pa_r     <= head.pa;
      pb_r     <= head.pb;
      pc_r     <= head.pc;
      pd_r     <= head.pd;
      even_r   <= head.even;
      even2_r  <= head.even2;
      second_r <= 1'b0;
      sub_r    <= '0;
      c_r      <= (head.job == JOB_STAR_ROOT || head.rank == '0) ? CNT_W'(1) : '0;
      phase_r  <= (head.rank == '0) ? PH_SELF : PH_LOW;
    end else if (emit) begin
      sub_r    <= sub_nxt;
      xm_r     <= xm_nxt;
      pa_r     <= pa_nxt;
      pb_r     <= pb_nxt;
      even_r   <= even_nxt;
      second_r <= second_nxt;
      c_r      <= c_nxt;
      phase_r  <= phase_nxt;
    end
    if (emit) begin
      out_kind_r <= cur_kind;
      out_peer_r <= cur_peer;
      out_last_r <= cur_last;
    end
  end

endmodule

@@ src/neighbor_exchange_schedule_core.sv @@
// Neighbor exchange schedule: for a node rank, emits that node's ordered send and
// receive operations for the configured topology (star, ring, complete, k-reach
// ring, torus). Each result item carries op_kind, peer_node and last_op.
// Input channel in_*: one rank per item. Result channel out_*: one operation per
// item, last_op set on the final one. A rank that is out of range, or a mode with
// no operations, produces no result items at all.
// With the sequencer idle, the first operation of a rank reaches out_* through
// classify, queue write, sequencer load and output register; a torus rank also goes
// through a row/column split by repeated subtraction after classify. The sequencer
// then emits one operation per cycle while the output is not stalled, and loads the
// next descriptor from the queue only once the current schedule is done; a schedule
// holds at most 64 operations. The front end takes no new rank until it has dropped
// or pushed the last one, and it waits while the two-entry queue is full.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce. Reset
// (rst_n low, synchronous) empties the queue and output register and sets mode empty
// with all other configuration registers at 1. A stalled output item holds, and the
// sequencer and then the queue and the input channel back up behind it.
// Depends on nes_pkg, nes_front, nes_queue and nes_back.
module neighbor_exchange_schedule_core
  import nes_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [RANK_W-1:0]     in_node_rank,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_op_kind,
  output logic [RANK_W-1:0]     out_peer_node,
  output logic                  out_last_op,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [MODE_W-1:0]  mode_r;
  logic [CNT_W-1:0]   nodes_r;
  logic [REACH_W-1:0] reach_r;
  logic [CNT_W-1:0]   height_r;
  logic [CNT_W-1:0]   width_r;
  cfg_t               cfg;

  logic  q_push, q_full, q_pop, q_empty;
  desc_t q_in, q_head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_EMPTY;
      nodes_r  <= CNT_W'(1);
      reach_r  <= REACH_W'(1);
      height_r <= CNT_W'(1);
      width_r  <= CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_wdata[MODE_W-1:0];
        CFG_NODES:  nodes_r  <= cfg_wdata[CNT_W-1:0];
        CFG_REACH:  reach_r  <= cfg_wdata[REACH_W-1:0];
        CFG_HEIGHT: height_r <= cfg_wdata[CNT_W-1:0];
        CFG_WIDTH:  width_r  <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{mode: mode_r, node_count: nodes_r, ring_reach: reach_r,
                 torus_h: height_r, torus_w: width_r};

  nes_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_node_rank (in_node_rank),
    .cfg          (cfg),
    .push         (q_push),
    .push_desc    (q_in),
    .full         (q_full)
  );

  nes_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  nes_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (q_empty),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_op_kind   (out_op_kind),
    .out_peer_node (out_peer_node),
    .out_last_op   (out_last_op)
  );

endmodule

@@ src/nes_checker.sv @@
// Port-level checks of the neighbor exchange block, bound to the top level.
// Depends on nes_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nes_checker
  import nes_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [RANK_W-1:0]     in_node_rank,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_op_kind,
  input logic [RANK_W-1:0]     out_peer_node,
  input logic                  out_last_op
);

  // A stalled result item keeps its payload.
  `NES_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_op_kind) && $stable(out_peer_node) && $stable(out_last_op), "stalled result changed")

  // A stalled input item keeps its rank.
  `NES_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(in_node_rank), "stalled rank changed")

  // The front end is busy in the cycle after it takes a rank.
  `NES_ASSERT(a_in_busy, in_valid && !in_stall |=> in_stall, "input taken twice in a row")

  // Operations of one schedule follow without gaps once the receiver takes them.
  `NES_ASSERT(a_burst, out_valid && !out_stall && !out_last_op |=> out_valid, "gap inside a schedule")

  // Reset leaves the block empty and ready for a rank.
  `NES_ASSERT_RST(a_reset, !rst_n |=> !out_valid && !in_stall, "block not idle after reset")

endmodule

bind neighbor_exchange_schedule_core nes_checker u_nes_checker (.*);
